@@ rtl/glc_pkg.sv @@
// glc_pkg: shared constants and types of the g-code line comment stripper
// no dependencies; used by every rtl file of the block
package glc_pkg;

    // parenthesis depth counter
    localparam int DEPTH_BITS = 8;
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

    // item queue between front and back
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // verdict codes
    localparam logic [1:0] VERDICT_KEPT     = 2'd0;
    localparam logic [1:0] VERDICT_EMPTY    = 2'd1;
    localparam logic [1:0] VERDICT_FALLBACK = 2'd2;

    // result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // classified item handed from front to back
    typedef struct packed {
        logic       keep;
        logic [7:0] ch;
        logic       eol;
        logic [1:0] verdict;
    } t_entry;

endpackage

@@ rtl/gcode_line_comment_stripper_top.sv @@
// Each result item goes through the item queue and then the output register; a character
// that gives both a kept character and the verdict shows the kept character first.
// Throughput: one character per cycle while the queue is not full; the output register
// sends one result per cycle unless stalled, so such line-end characters give two results.
// Reset: synchronous, active low; clears line state, the item queue and the output register.
module gcode_line_comment_stripper_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_line,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_result_kind,
    output logic [7:0] o_kept_char,
    output logic [1:0] o_verdict,
    output logic       o_last_of_line
);

    glc_pkg::t_entry push_entry, head_entry;
    logic            accept, push, pop, q_full, q_empty;

    // input side stalls only on a full queue
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    glc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_char_code   (i_char_code),
        .i_end_of_line (i_end_of_line),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    glc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    glc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head_entry),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_kept_char    (o_kept_char),
        .o_verdict      (o_verdict),
        .o_last_of_line (o_last_of_line)
    );

endmodule

@@ rtl/glc_front.sv @@
// glc_front: accepts characters, tracks line state and classifies each item
// depends on glc_pkg
module glc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_char_code,
    input  logic            i_end_of_line,
    output logic            o_push,
    output glc_pkg::t_entry o_entry
);

    typedef enum logic [1:0] {PH_SKIP, PH_BODY, PH_FALL, PH_DONE} t_phase;

    t_phase                                 r_phase, n_phase;
    logic signed [glc_pkg::DEPTH_BITS-1:0]  r_depth, n_depth, dec_depth;
    logic                                   r_flag, n_flag;
    logic                                   r_kept, n_kept;
    logic                                   keep, do_body;
    logic [1:0]                             verdict;

    // next line state for the offered character
    always_comb begin
        n_phase   = r_phase;
        n_depth   = r_depth;
        n_flag    = r_flag;
        n_kept    = r_kept;
        keep      = 1'b0;
        do_body   = 1'b0;
        dec_depth = r_depth;
        case (r_phase)
            PH_SKIP: begin
                if (i_char_code == glc_pkg::CH_SPACE || i_char_code == glc_pkg::CH_TAB) begin
                    n_phase = PH_SKIP;
                end else if (i_char_code == glc_pkg::CH_DOLLAR
                          || i_char_code == glc_pkg::CH_UNDER
                          || i_char_code == glc_pkg::CH_PCT) begin
                    n_phase = PH_FALL;
                end else if (i_char_code == glc_pkg::CH_SEMI) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_BODY;
                    do_body = 1'b1;
                end
            end
            PH_BODY: begin
                do_body = 1'b1;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // body character handling
        if (do_body) begin
            case (i_char_code)
                glc_pkg::CH_NUL: begin
                    n_phase = PH_DONE;
                end
                glc_pkg::CH_LPAREN: begin
                    if (r_depth != glc_pkg::DEPTH_MAX) begin
                        n_depth = r_depth + glc_pkg::DEPTH_ONE;
                    end
                    n_flag = 1'b1;
                end
                glc_pkg::CH_RPAREN: begin
                    if (r_depth != glc_pkg::DEPTH_MIN) begin
                        dec_depth = r_depth - glc_pkg::DEPTH_ONE;
                    end
                    n_depth = dec_depth;
                    if (dec_depth == '0) begin
                        n_flag = 1'b0;
                    end
                end
                glc_pkg::CH_LBRACK, glc_pkg::CH_RBRACK: begin
                    if (!r_flag) begin
                        n_phase = PH_FALL;
                    end
                end
                glc_pkg::CH_EQUAL: begin
                    if (!r_flag) begin
                        n_phase = PH_FALL;
                    end else begin
                        n_flag = 1'b1;
                    end
                end
                glc_pkg::CH_SEMI: begin
                    n_flag = 1'b1;
                end
                glc_pkg::CH_SPACE, glc_pkg::CH_LF: begin
                    keep = 1'b0;
                end
                default: begin
                    if (!r_flag) begin
                        keep   = 1'b1;
                        n_kept = 1'b1;
                    end
                end
            endcase
        end

        // line verdict
        if (n_phase == PH_FALL) begin
            verdict = glc_pkg::VERDICT_FALLBACK;
        end else if (n_kept) begin
            verdict = glc_pkg::VERDICT_KEPT;
        end else begin
            verdict = glc_pkg::VERDICT_EMPTY;
        end
    end

    // queue entry for the accepted item
    assign o_push          = i_accept && (keep || i_end_of_line);
    assign o_entry.keep    = keep;
    assign o_entry.ch      = i_char_code;
    assign o_entry.eol     = i_end_of_line;
    assign o_entry.verdict = verdict;

    // line state, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_depth <= '0;
            r_flag  <= 1'b0;
            r_kept  <= 1'b0;
        end else if (i_accept) begin
            if (i_end_of_line) begin
                r_phase <= PH_SKIP;
                r_depth <= '0;
                r_flag  <= 1'b0;
                r_kept  <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_depth <= n_depth;
                r_flag  <= n_flag;
                r_kept  <= n_kept;
            end
        end
    end

endmodule

@@ rtl/glc_queue.sv @@
// glc_queue: short register queue of classified items between front and back
// depends on glc_pkg
module glc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  glc_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output glc_pkg::t_entry o_head
);

    glc_pkg::t_entry                r_mem [glc_pkg::QDEPTH];
    logic [glc_pkg::QPTR_BITS-1:0]  r_wr_ptr, r_rd_ptr;
    logic [glc_pkg::QCNT_BITS-1:0]  r_count;

    assign o_full  = (r_count == glc_pkg::QCNT_BITS'(glc_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/glc_back.sv @@
// glc_back: expands queued items into result items and holds the output register
// depends on glc_pkg
module glc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  glc_pkg::t_entry i_head,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic            o_result_kind,
    output logic [7:0]      o_kept_char,
    output logic [1:0]      o_verdict,
    output logic            o_last_of_line
);

    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_char;
    logic [1:0] r_verdict;
    logic       r_char_done;
    logic       load, send_char;

    // load the next result when the output register is free or being taken
    assign load      = !i_empty && (!r_valid || !i_stall);
    assign send_char = i_head.keep && !r_char_done;
    assign o_pop     = load && !(send_char && i_head.eol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_char_done <= 1'b0;
        end else begin
            if (load) begin
                r_valid     <= 1'b1;
                r_char_done <= send_char && i_head.eol;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (send_char) begin
                r_kind    <= glc_pkg::KIND_CHAR;
                r_char    <= i_head.ch;
                r_verdict <= glc_pkg::VERDICT_KEPT;
            end else begin
                r_kind    <= glc_pkg::KIND_VERDICT;
                r_char    <= '0;
                r_verdict <= i_head.verdict;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_result_kind  = r_kind;
    assign o_kept_char    = r_char;
    assign o_verdict      = r_verdict;
    assign o_last_of_line = (r_kind == glc_pkg::KIND_VERDICT);

endmodule

@@ rtl/glc_checker.sv @@
// glc_checker: port-level assertions of the comment stripper and its bind
// depends on glc_pkg and gcode_line_comment_stripper_top
module glc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_result_kind,
    input logic [7:0] o_kept_char,
    input logic [1:0] o_verdict,
    input logic       o_last_of_line
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind) && $stable(o_kept_char)
            && $stable(o_verdict) && $stable(o_last_of_line))
        else $error("stalled result changed");

    // only verdicts close a line
    a_last_is_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_line == (o_result_kind == glc_pkg::KIND_VERDICT)))
        else $error("last_of_line does not match result kind");

    // kept characters never include dropped codes
    a_kept_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == glc_pkg::KIND_CHAR) |->
            o_kept_char != glc_pkg::CH_SPACE && o_kept_char != glc_pkg::CH_LF
            && o_kept_char != glc_pkg::CH_NUL && o_verdict == glc_pkg::VERDICT_KEPT)
        else $error("dropped character emitted");

    // verdict results carry a valid code and no character
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == glc_pkg::KIND_VERDICT) |->
            o_kept_char == '0 && (o_verdict == glc_pkg::VERDICT_KEPT
            || o_verdict == glc_pkg::VERDICT_EMPTY || o_verdict == glc_pkg::VERDICT_FALLBACK))
        else $error("bad verdict result");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

bind gcode_line_comment_stripper_top glc_checker u_glc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_kind  (o_result_kind),
    .o_kept_char    (o_kept_char),
    .o_verdict      (o_verdict),
    .o_last_of_line (o_last_of_line)
);

@@ bench/tb.sv @@
// tb: self-checking bench for gcode_line_comment_stripper_top, stripped chars and line verdicts
// depends on rtl/glc_pkg.sv for character, verdict and kind codes and the depth limits
// a behavioral line tracker predicts each result; random bursts, stalls and long hold-offs
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import glc_pkg::*;

    localparam int ITEM_TARGET = 1650;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef logic [7:0] t_bytes[$];

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [1:0] verdict;
        logic       last;
    } t_result;

    typedef enum logic [1:0] {LN_SKIP, LN_BODY, LN_FALLBACK, LN_SWALLOW} t_line_phase;
    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY} t_rx_mode;

    // dut ports
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       o_stall;
    logic [7:0] i_char_code   = '0;
    logic       i_end_of_line = 1'b0;
    logic       o_valid;
    logic       i_stall       = 1'b0;
    logic       o_result_kind;
    logic [7:0] o_kept_char;
    logic [1:0] o_verdict;
    logic       o_last_of_line;

    // line tracker state
    t_line_phase                  line_phase  = LN_SKIP;
    logic signed [DEPTH_BITS-1:0] paren_level = '0;
    logic                         in_comment  = 1'b0;
    logic                         kept_seen   = 1'b0;

    t_result pending_results[$];

    // run bookkeeping
    int fail_count      = 0;
    int idle_cycles     = 0;
    int chars_accepted  = 0;
    int lines_accepted  = 0;
    int results_checked = 0;
    int sat_hits        = 0;
    int in_stall_cycles = 0;
    int verdict_seen[3] = '{0, 0, 0};

    // traffic shaping
    logic     tx_gaps_on    = 1'b0;
    int       tx_burst_left = 0;
    t_rx_mode rx_mode       = RX_OPEN;
    int       hold_request  = 0;
    int       hold_left     = 0;
    int       rx_busy_run   = 0;
    int       rx_free_run   = 0;

    gcode_line_comment_stripper_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_end_of_line  (i_end_of_line),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_kept_char    (o_kept_char),
        .o_verdict      (o_verdict),
        .o_last_of_line (o_last_of_line)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one body character: updates depth, comment and phase, returns 1 if kept
    function automatic logic body_char(input logic [7:0] c);
        case (c)
            CH_NUL: line_phase = LN_SWALLOW;
            CH_LPAREN: begin
                if (paren_level != DEPTH_MAX) paren_level = paren_level + DEPTH_ONE;
                else sat_hits++;
                in_comment = 1'b1;
            end
            CH_RPAREN: begin
                if (paren_level != DEPTH_MIN) paren_level = paren_level - DEPTH_ONE;
                else sat_hits++;
                if (paren_level == 0) in_comment = 1'b0;
            end
            CH_LBRACK, CH_RBRACK: begin
                if (!in_comment) line_phase = LN_FALLBACK;
            end
            CH_EQUAL: begin
                if (!in_comment) line_phase = LN_FALLBACK;
                else in_comment = 1'b1;
            end
            CH_SEMI: in_comment = 1'b1;
            CH_SPACE, CH_LF: ;
            default: begin
                if (!in_comment) begin
                    kept_seen = 1'b1;
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    // expected results of one accepted character
    function automatic void predict_char(input logic [7:0] c, input logic eol);
        t_result r;
        logic    keep;
        keep = 1'b0;
        case (line_phase)
            LN_SKIP: begin
                if (c == CH_DOLLAR || c == CH_UNDER || c == CH_PCT) begin
                    line_phase = LN_FALLBACK;
                end else if (c == CH_SEMI) begin
                    line_phase = LN_SWALLOW;
                end else if (c != CH_SPACE && c != CH_TAB) begin
                    line_phase = LN_BODY;
                    keep = body_char(c);
                end
            end
            LN_BODY: keep = body_char(c);
            default: ;
        endcase
        if (keep) begin
            r = '{kind: KIND_CHAR, ch: c, verdict: VERDICT_KEPT, last: 1'b0};
            pending_results = {pending_results, r};
        end
        if (eol) begin
            r = '{kind: KIND_VERDICT, ch: 8'h00, verdict: VERDICT_EMPTY, last: 1'b1};
            if (line_phase == LN_FALLBACK) r.verdict = VERDICT_FALLBACK;
            else if (kept_seen) r.verdict = VERDICT_KEPT;
            pending_results = {pending_results, r};
            line_phase  = LN_SKIP;
            paren_level = '0;
            in_comment  = 1'b0;
            kept_seen   = 1'b0;
            lines_accepted++;
        end
    endfunction

    // compare results first, then predict from the char accepted at this edge
    always @(posedge i_clk) begin
        t_result r;
        logic    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: kind %0d char %h verdict %0d",
                           o_result_kind, o_kept_char, o_verdict);
                    fail_count++;
                end else begin
                    r = pending_results.pop_front();
                    results_checked++;
                    if (o_result_kind !== r.kind) begin
                        $error("result_kind: expected %0d, got %0d", r.kind, o_result_kind);
                        fail_count++;
                    end
                    if (o_kept_char !== r.ch) begin
                        $error("kept_char: expected %h, got %h", r.ch, o_kept_char);
                        fail_count++;
                    end
                    if (o_verdict !== r.verdict) begin
                        $error("verdict: expected %0d, got %0d", r.verdict, o_verdict);
                        fail_count++;
                    end
                    if (o_last_of_line !== r.last) begin
                        $error("last_of_line: expected %0d, got %0d", r.last, o_last_of_line);
                        fail_count++;
                    end
                    if (r.kind == KIND_VERDICT) verdict_seen[r.verdict]++;
                end
            end
            if (i_valid && o_stall) in_stall_cycles++;
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                chars_accepted++;
                predict_char(i_char_code, i_end_of_line);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // receiver stall: long hold-off on request, else its own run pattern
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_mode == RX_OPEN) begin
            i_stall <= 1'b0;
        end else if (rx_busy_run != 0) begin
            rx_busy_run--;
            i_stall <= 1'b1;
        end else if (rx_free_run != 0) begin
            rx_free_run--;
            i_stall <= 1'b0;
        end else begin
            rx_busy_run = $urandom_range(1, (rx_mode == RX_HEAVY) ? 6 : 2);
            rx_free_run = $urandom_range(0, (rx_mode == RX_HEAVY) ? 3 : 8);
            i_stall <= 1'b0;
        end
    end

    // idle watchdog
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $error("no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // offer one char, with a random gap between bursts when enabled
    task automatic send_char(input logic [7:0] c, input logic eol);
        if (tx_gaps_on && tx_burst_left == 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
            tx_burst_left = $urandom_range(1, 12);
        end
        if (tx_burst_left != 0) tx_burst_left--;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_char_code   <= c;
        i_end_of_line <= eol;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_line(input t_bytes text);
        foreach (text[k]) send_char(text[k], k == text.size() - 1);
    endtask

    // stop offering and wait for every expected result
    task automatic pause_until_drained();
        @(negedge i_clk) i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_bytes to_bytes(input string s);
        t_bytes q;
        for (int k = 0; k < s.len(); k++) q = {q, s[k]};
        return q;
    endfunction

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // random line: mostly plausible g-code with comments, some prefixes and raw noise
    function automatic t_bytes random_line();
        t_bytes q;
        int     kind;
        int     sel;
        int     unclosed;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 8)) q = {q, 8'($urandom_range(0, 255))};
            return q;
        end
        repeat ($urandom_range(0, 2)) q = {q, pick_from(" \t")};
        if (kind < 16) q = {q, pick_from("$_%")};
        else if (kind < 20) q = {q, CH_SEMI};
        repeat ($urandom_range(1, 4)) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                q = {q, pick_from("GMXYZFSTIJ")};
                repeat ($urandom_range(1, 3)) q = {q, pick_from("0123456789.-")};
            end else if (sel < 75) begin
                // parenthesized comment, possibly nested or left open
                q = {q, CH_LPAREN};
                unclosed = 1;
                repeat ($urandom_range(0, 6)) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 12) begin
                        q = {q, CH_LPAREN};
                        unclosed++;
                    end else if (sel < 22 && unclosed > 1) begin
                        q = {q, CH_RPAREN};
                        unclosed--;
                    end else begin
                        q = {q, pick_from("ABxy09 =[];\t")};
                    end
                end
                if ($urandom_range(0, 9) == 0) unclosed--;
                repeat (unclosed) q = {q, CH_RPAREN};
            end else if (sel < 82) begin
                q = {q, CH_SEMI};
                repeat ($urandom_range(0, 4)) q = {q, pick_from("abc1 =[(")};
            end else if (sel < 88) begin
                q = {q, pick_from("#X")};
                q = {q, pick_from("=[]")};
                q = {q, pick_from("12")};
            end else if (sel < 93) begin
                q = {q, pick_from("()")};
            end else if (sel < 96) begin
                q = {q, CH_NUL};
            end else begin
                q = {q, 8'($urandom_range(0, 255))};
            end
            sel = $urandom_range(0, 9);
            if (sel < 4) q = {q, CH_SPACE};
            else if (sel == 4) q = {q, CH_TAB};
        end
        if ($urandom_range(0, 4) == 0) q = {q, CH_LF};
        return q;
    endfunction

    // random mix of sender gaps and receiver stall pattern, sometimes none
    task automatic shuffle_traffic();
        tx_gaps_on = $urandom_range(0, 2) != 0;
        case ($urandom_range(0, 2))
            0: rx_mode = RX_OPEN;
            1: rx_mode = RX_LIGHT;
            default: rx_mode = RX_HEAVY;
        endcase
    endtask

    // blanks, prefixes, comments, expression chars, byte extremes, zero byte
    task automatic test_directed_lines();
        t_bytes q;
        tx_gaps_on = 1'b0;
        rx_mode    = RX_OPEN;
        send_line(to_bytes("\t $A"));
        send_line(to_bytes("_"));
        send_line(to_bytes("%"));
        send_line(to_bytes(";G"));
        send_line(to_bytes("G(=)\t"));
        send_line(to_bytes("A=B"));
        q = {8'hFF, CH_NUL, 8'h5A};
        send_line(q);
        send_line(to_bytes(" \n"));
        send_line(to_bytes("(]"));
        send_line(to_bytes("]"));
        pause_until_drained();
    endtask

    // depth driven past both counter limits, then back to zero
    task automatic test_depth_saturation();
        t_bytes q;
        int     n;
        tx_gaps_on = 1'b1;
        rx_mode    = RX_LIGHT;
        n = $urandom_range(128, 140);
        q = to_bytes("G1");
        repeat (n) q = {q, CH_LPAREN};
        q = {q, pick_from("abX")};
        repeat (n) q = {q, CH_RPAREN};
        q = {q, pick_from("XYZ")};
        repeat ($urandom_range(1, 4)) q = {q, CH_RPAREN};
        q = {q, pick_from("XYZ")};
        send_line(q);
        n = $urandom_range(129, 140);
        q = to_bytes("M");
        repeat (n) q = {q, CH_RPAREN};
        q = {q, pick_from("FST")};
        repeat (n) q = {q, CH_LPAREN};
        repeat ($urandom_range(0, 3)) q = {q, pick_from("ab=")};
        repeat ($urandom_range(DEPTH_BITS - 1, 12)) q = {q, CH_RPAREN};
        q = {q, pick_from("IJ")};
        send_line(q);
        pause_until_drained();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_hold_off();
        tx_gaps_on   = 1'b0;
        rx_mode      = RX_OPEN;
        hold_request = HOLD_CYCLES;
        repeat (6) send_line(random_line());
        pause_until_drained();
    endtask

    // sender stops between groups of lines until all results are back
    task automatic test_drain_pauses();
        repeat (5) begin
            shuffle_traffic();
            repeat ($urandom_range(1, 3)) send_line(random_line());
            pause_until_drained();
        end
    endtask

    // bulk random lines under changing traffic
    task automatic test_random_lines();
        int n;
        n = 0;
        while (chars_accepted < ITEM_TARGET) begin
            if (n % 24 == 0) shuffle_traffic();
            send_line(random_line());
            n++;
        end
        pause_until_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_directed_lines();
        test_depth_saturation();
        test_output_hold_off();
        test_drain_pauses();
        test_random_lines();

        rx_mode = RX_OPEN;
        repeat (8) @(posedge i_clk);

        $display("covered %0d lines, %0d chars, %0d results (kept %0d, empty %0d, fallback %0d)",
                 lines_accepted, chars_accepted, results_checked,
                 verdict_seen[VERDICT_KEPT], verdict_seen[VERDICT_EMPTY],
                 verdict_seen[VERDICT_FALLBACK]);
        $display("depth limit hits %0d, input stall cycles %0d", sat_hits, in_stall_cycles);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/glc_pkg.sv
rtl/glc_front.sv
rtl/glc_queue.sv
rtl/glc_back.sv
rtl/gcode_line_comment_stripper_top.sv
rtl/glc_checker.sv
bench/tb.sv
